@@ src/assert_macros.svh @@
// Assertion macros used by the quaternion rate integrator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, reset-qualified.
`define QRI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, reset-qualified.
`define QRI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QRI_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define QRI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/qri_pkg.sv @@
// Package: widths, constants, state codes and helpers of the quaternion rate integrator.
package qri_pkg;
    localparam int QUAT_WIDTH = 32;
    localparam logic signed [QUAT_WIDTH-1:0] QONE = 32'sh4000_0000;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DMUL  = 4'd1;
    localparam logic [3:0] ST_PMUL  = 4'd2;
    localparam logic [3:0] ST_ZCHK  = 4'd3;
    localparam logic [3:0] ST_SQ    = 4'd4;
    localparam logic [3:0] ST_SQRT  = 4'd5;
    localparam logic [3:0] ST_DINIT = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    localparam logic ACT_INTEGRATE = 1'b0;
    localparam logic ACT_LOAD      = 1'b1;

    typedef struct packed {
        logic [1:0] d_idx;
        logic [1:0] q_idx;
        logic       neg;
    } t_term_sel;

    // Term k of the twelve rate-by-quaternion products (three per component).
    function automatic t_term_sel term_sel(input logic [3:0] k);
        t_term_sel s;
        s = '{d_idx: 2'd0, q_idx: 2'd0, neg: 1'b0};
        unique case (k)
            4'd0:  s = '{d_idx: 2'd0, q_idx: 2'd1, neg: 1'b1};
            4'd1:  s = '{d_idx: 2'd1, q_idx: 2'd2, neg: 1'b1};
            4'd2:  s = '{d_idx: 2'd2, q_idx: 2'd3, neg: 1'b1};
            4'd3:  s = '{d_idx: 2'd0, q_idx: 2'd0, neg: 1'b0};
            4'd4:  s = '{d_idx: 2'd1, q_idx: 2'd3, neg: 1'b0};
            4'd5:  s = '{d_idx: 2'd2, q_idx: 2'd2, neg: 1'b1};
            4'd6:  s = '{d_idx: 2'd1, q_idx: 2'd0, neg: 1'b0};
            4'd7:  s = '{d_idx: 2'd2, q_idx: 2'd1, neg: 1'b0};
            4'd8:  s = '{d_idx: 2'd0, q_idx: 2'd3, neg: 1'b1};
            4'd9:  s = '{d_idx: 2'd2, q_idx: 2'd0, neg: 1'b0};
            4'd10: s = '{d_idx: 2'd0, q_idx: 2'd2, neg: 1'b0};
            4'd11: s = '{d_idx: 2'd1, q_idx: 2'd1, neg: 1'b1};
            default: s = '{d_idx: 2'd0, q_idx: 2'd0, neg: 1'b0};
        endcase
        return s;
    endfunction

    // Clip to signed 32 bits; MSB of the result flags a clip.
    function automatic logic [QUAT_WIDTH:0] clip_q(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -66'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[QUAT_WIDTH-1:0]};
    endfunction

    function automatic logic [QUAT_WIDTH-1:0] mag(input logic signed [QUAT_WIDTH-1:0] c);
        return c[QUAT_WIDTH-1] ? -c : c;
    endfunction
endpackage

@@ src/qri_if.sv @@
// Valid/ready channel interfaces for the input and result words.
interface qri_in_if;
    import qri_pkg::*;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic signed [QUAT_WIDTH-1:0]  rate_x;
    logic signed [QUAT_WIDTH-1:0]  rate_y;
    logic signed [QUAT_WIDTH-1:0]  rate_z;
    logic        [QUAT_WIDTH-1:0]  step_scale;
    logic signed [QUAT_WIDTH-1:0]  load_w;
    logic signed [QUAT_WIDTH-1:0]  load_x;
    logic signed [QUAT_WIDTH-1:0]  load_y;
    logic signed [QUAT_WIDTH-1:0]  load_z;
    modport source(output valid, action, rate_x, rate_y, rate_z, step_scale,
                   load_w, load_x, load_y, load_z, input ready);
    modport sink(input valid, action, rate_x, rate_y, rate_z, step_scale,
                 load_w, load_x, load_y, load_z, output ready);
endinterface

interface qri_out_if;
    import qri_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [QUAT_WIDTH-1:0]  out_w;
    logic signed [QUAT_WIDTH-1:0]  out_x;
    logic signed [QUAT_WIDTH-1:0]  out_y;
    logic signed [QUAT_WIDTH-1:0]  out_z;
    logic                          zero_norm;
    logic                          saturated;
    modport source(output valid, out_w, out_x, out_y, out_z, zero_norm, saturated,
                   input ready);
    modport sink(input valid, out_w, out_x, out_y, out_z, zero_norm, saturated,
                 output ready);
endinterface

@@ src/quaternion_rate_integrator.sv @@
// Quaternion rate integrator: orientation state, shared multiplier and sequencer.
//
// Usage: input words arrive on i_in (valid/ready). action=1 loads the
// quaternion from load_w..z as given; action=0 integrates the rate vector
// times step_scale into the stored orientation and renormalizes it.
// Every input word yields exactly one result word on o_out: the quaternion
// after the word plus zero_norm and saturated flags.
// A load passes through the hand-over state into the output register. An
// integrate works out the three scaled rates, the twelve cross products, a
// zero check and the four squares (all on one shared 33x33 multiplier, each
// product issued and then consumed), then the bit-serial square root (not
// needed for a full-scale sum), four bit-serial normalizing divisions and
// the hand-over. A zero-norm integrate skips the norm. A new word is taken
// only once the last one is handed over; i_in.ready is high only while the
// sequencer is idle.
// Reset: orientation returns to identity (w=1.0), the output register is
// emptied and the sequencer goes idle.
// Stall: a finished result waits in the output register; a following word
// is taken and worked on meanwhile and only its hand-over waits for the
// receiver to take the earlier one.
module quaternion_rate_integrator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qri_in_if.sink    i_in,
    qri_out_if.source o_out
);
    import qri_pkg::*;
    `include "assert_macros.svh"

    logic [3:0]                 r_state;
    logic [3:0]                 r_k;        // product index
    logic [1:0]                 r_t;        // term within component
    logic [1:0]                 r_comp;
    logic                       r_ph;       // 0 issue multiply, 1 consume
    logic [4:0]                 r_cnt;
    logic signed [QUAT_WIDTH-1:0] r_rate [3];
    logic [QUAT_WIDTH-1:0]      r_step;
    logic signed [QUAT_WIDTH-1:0] r_d [3];
    logic signed [QUAT_WIDTH-1:0] r_q [4];   // orientation state
    logic signed [QUAT_WIDTH-1:0] r_n [4];   // unnormalized sum
    logic signed [65:0]         r_prod;
    logic signed [65:0]         r_acc;
    logic [64:0]                r_s;
    logic [33:0]                r_sq_rem;
    logic [32:0]                r_root;
    logic [63:0]                r_sbits;
    logic [33:0]                r_drem;
    logic [30:0]                r_nlo;
    logic [30:0]                r_quo;
    logic                       r_sat;
    logic                       r_zero;
    logic                       r_ovalid;
    logic signed [QUAT_WIDTH-1:0] r_ow, r_ox, r_oy, r_oz;
    logic                       r_ozero, r_osat;

    // shared multiplier operands
    logic signed [32:0]         n_ma, n_mb;
    logic signed [65:0]         n_prod;
    t_term_sel                  sel;
    logic [QUAT_WIDTH-1:0]      cmag;

    assign sel  = term_sel(r_k);
    assign cmag = mag(r_n[r_comp]);

    always_comb begin
        n_ma = '0;
        n_mb = '0;
        unique case (r_state)
            ST_DMUL: begin
                n_ma = {r_rate[r_k[1:0]][QUAT_WIDTH-1], r_rate[r_k[1:0]]};
                n_mb = {1'b0, r_step};
            end
            ST_PMUL: begin
                n_ma = {r_d[sel.d_idx][QUAT_WIDTH-1], r_d[sel.d_idx]};
                n_mb = {r_q[sel.q_idx][QUAT_WIDTH-1], r_q[sel.q_idx]};
            end
            ST_SQ: begin
                n_ma = {1'b0, cmag};
                n_mb = {1'b0, cmag};
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
    end

    assign n_prod = n_ma * n_mb;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // combinational helpers for the consume phases
    logic [QUAT_WIDTH:0]        d_clip;
    logic signed [65:0]         p_term, p_base, p_sum;
    logic [QUAT_WIDTH:0]        n_clip;
    logic [64:0]                s_next;
    logic [35:0]                sq_t, sq_trial;
    logic [63:0]                div_n;
    logic [34:0]                dv_t;
    logic [33:0]                dv_d;
    logic                       dv_ge;
    logic [30:0]                quo_fin;
    logic signed [QUAT_WIDTH-1:0] quo_s;

    assign d_clip   = clip_q((r_prod + 66'sd2097152) >>> 22);
    assign p_term   = (sel.neg ? -r_prod : r_prod) >>> 2;
    assign p_base   = (r_t == 2'd0)
                    ? ({{34{r_q[r_comp][QUAT_WIDTH-1]}}, r_q[r_comp]} <<< 29) : r_acc;
    assign p_sum    = p_base + p_term;
    assign n_clip   = clip_q((p_sum + 66'sd268435456) >>> 29);
    assign s_next   = r_s + {1'b0, r_prod[63:0]};
    assign sq_t     = {r_sq_rem, r_sbits[63:62]};
    assign sq_trial = {2'b00, r_root[31:0], 2'b01};
    assign div_n    = {1'b0, cmag, 31'd0} + {31'd0, r_root};
    assign dv_d     = {r_root, 1'b0};
    assign dv_t     = {r_drem, r_nlo[30]};
    assign dv_ge    = dv_t >= {1'b0, dv_d};
    assign quo_fin  = {r_quo[29:0], dv_ge};
    assign quo_s    = r_n[r_comp][QUAT_WIDTH-1] ? -{1'b0, quo_fin} : {1'b0, quo_fin};

    logic in_acc, out_free;
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_q[0]   <= QONE;
            r_q[1]   <= '0;
            r_q[2]   <= '0;
            r_q[3]   <= '0;
            r_k      <= '0;
            r_t      <= '0;
            r_comp   <= '0;
            r_ph     <= 1'b0;
            r_cnt    <= '0;
            r_sat    <= 1'b0;
            r_zero   <= 1'b0;
        end else begin
            // hand-over fills the output register, a take empties it
            if (r_state == ST_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_sat  <= 1'b0;
                        r_zero <= 1'b0;
                        if (i_in.action == ACT_LOAD) begin
                            r_q[0]  <= i_in.load_w;
                            r_q[1]  <= i_in.load_x;
                            r_q[2]  <= i_in.load_y;
                            r_q[3]  <= i_in.load_z;
                            r_state <= ST_DONE;
                        end else begin
                            r_rate[0] <= i_in.rate_x;
                            r_rate[1] <= i_in.rate_y;
                            r_rate[2] <= i_in.rate_z;
                            r_step    <= i_in.step_scale;
                            r_k       <= '0;
                            r_ph      <= 1'b0;
                            r_state   <= ST_DMUL;
                        end
                    end
                end
                ST_DMUL: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_d[r_k[1:0]] <= d_clip[QUAT_WIDTH-1:0];
                        if (d_clip[QUAT_WIDTH]) r_sat <= 1'b1;
                        if (r_k == 4'd2) begin
                            r_k     <= '0;
                            r_t     <= '0;
                            r_comp  <= '0;
                            r_state <= ST_PMUL;
                        end else begin
                            r_k <= r_k + 4'd1;
                        end
                    end
                end
                ST_PMUL: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_acc <= p_sum;
                        r_k   <= r_k + 4'd1;
                        if (r_t == 2'd2) begin
                            r_t           <= '0;
                            r_n[r_comp]   <= n_clip[QUAT_WIDTH-1:0];
                            if (n_clip[QUAT_WIDTH]) r_sat <= 1'b1;
                            r_comp        <= r_comp + 2'd1;
                            if (r_comp == 2'd3) r_state <= ST_ZCHK;
                        end else begin
                            r_t <= r_t + 2'd1;
                        end
                    end
                end
                ST_ZCHK: begin
                    if (r_n[0] == '0 && r_n[1] == '0 && r_n[2] == '0 && r_n[3] == '0) begin
                        r_zero  <= 1'b1;
                        r_q[0]  <= QONE;
                        r_q[1]  <= '0;
                        r_q[2]  <= '0;
                        r_q[3]  <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_s     <= '0;
                        r_comp  <= '0;
                        r_ph    <= 1'b0;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_s    <= s_next;
                        r_comp <= r_comp + 2'd1;
                        if (r_comp == 2'd3) begin
                            r_sbits  <= s_next[63:0];
                            r_sq_rem <= '0;
                            r_cnt    <= '0;
                            // full-scale sum: every component at -2.0
                            if (s_next[64]) begin
                                r_root  <= 33'h1_0000_0000;
                                r_state <= ST_DINIT;
                            end else begin
                                r_root  <= '0;
                                r_state <= ST_SQRT;
                            end
                        end
                    end
                end
                ST_SQRT: begin
                    r_sbits <= {r_sbits[61:0], 2'b00};
                    if (sq_t >= sq_trial) begin
                        r_sq_rem <= 34'(sq_t - sq_trial);
                        r_root   <= {r_root[31:0], 1'b1};
                    end else begin
                        r_sq_rem <= sq_t[33:0];
                        r_root   <= {r_root[31:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_comp  <= '0;
                        r_state <= ST_DINIT;
                    end
                end
                ST_DINIT: begin
                    r_drem  <= {1'b0, div_n[63:31]};
                    r_nlo   <= div_n[30:0];
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_drem <= dv_ge ? 34'(dv_t - {1'b0, dv_d}) : dv_t[33:0];
                    r_nlo  <= {r_nlo[29:0], 1'b0};
                    r_quo  <= quo_fin;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd30) begin
                        r_q[r_comp] <= quo_s;
                        r_comp      <= r_comp + 2'd1;
                        r_state     <= (r_comp == 2'd3) ? ST_DONE : ST_DINIT;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output payload register, loaded on hand-over
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_ow    <= r_q[0];
            r_ox    <= r_q[1];
            r_oy    <= r_q[2];
            r_oz    <= r_q[3];
            r_ozero <= r_zero;
            r_osat  <= r_sat;
        end
    end

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.out_w     = r_ow;
    assign o_out.out_x     = r_ox;
    assign o_out.out_y     = r_oy;
    assign o_out.out_z     = r_oz;
    assign o_out.zero_norm = r_ozero;
    assign o_out.saturated = r_osat;

    logic out_ident;
    assign out_ident = (r_ow == QONE) && (r_ox == '0) && (r_oy == '0) && (r_oz == '0);

    // an accepted word always leaves the idle state
    `QRI_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, r_state != ST_IDLE)
    // a zero-norm result is exactly identity
    `QRI_ASSERT_NOW(a_zero_is_identity, i_clk, i_rst_n, r_ovalid && r_ozero, out_ident)
    // a result is never replaced before the receiver takes it
    `QRI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_ovalid && !o_out.ready, r_ovalid && $stable(r_ow) && $stable(r_osat))
endmodule

@@ tb/tb_quaternion_rate_integrator.sv @@
// Self-checking testbench for the quaternion rate integrator: predicted vs. DUT result words.
module tb_quaternion_rate_integrator;
    timeunit 1ns;
    timeprecision 1ps;
    import qri_pkg::*;

    // Wide signed math so nothing in the predictor can overflow.
    typedef logic signed [127:0] wide_t;
    typedef logic        [127:0] uwide_t;

    typedef struct {
        logic                         action;
        logic signed [QUAT_WIDTH-1:0] rate_x;
        logic signed [QUAT_WIDTH-1:0] rate_y;
        logic signed [QUAT_WIDTH-1:0] rate_z;
        logic        [QUAT_WIDTH-1:0] step_scale;
        logic signed [QUAT_WIDTH-1:0] load_w;
        logic signed [QUAT_WIDTH-1:0] load_x;
        logic signed [QUAT_WIDTH-1:0] load_y;
        logic signed [QUAT_WIDTH-1:0] load_z;
    } in_word_t;

    typedef struct {
        logic signed [QUAT_WIDTH-1:0] w;
        logic signed [QUAT_WIDTH-1:0] x;
        logic signed [QUAT_WIDTH-1:0] y;
        logic signed [QUAT_WIDTH-1:0] z;
        logic                         zero_norm;
        logic                         saturated;
    } orient_word_t;

    localparam int    CYCLE_LIMIT = 2_000_000;
    localparam int    N_RANDOM    = 1100;
    localparam wide_t Q_MAX       = 128'sd2147483647;
    localparam wide_t Q_MIN       = -128'sd2147483648;
    localparam wide_t RND_RATE    = 128'sd2097152;     // 2^21, rate*step rounding
    localparam wide_t RND_ACC     = 128'sd268435456;   // 2^28, accumulator rounding
    localparam uwide_t S_FULL     = 128'hFFFF_FFFF_FFFF_FFFF;

    // Orientation predictor plus queue of expected result words.
    class orient_tracker;
        logic signed [QUAT_WIDTH-1:0] qw, qx, qy, qz;
        orient_word_t expected_q[$];
        int errors, n_load, n_integ, n_zero, n_sat;

        function void reset_state();
            qw = QONE; qx = 0; qy = 0; qz = 0;
        endfunction

        function wide_t clip(wide_t v, inout bit sat);
            if (v > Q_MAX) begin
                sat = 1;
                return Q_MAX;
            end
            if (v < Q_MIN) begin
                sat = 1;
                return Q_MIN;
            end
            return v;
        endfunction

        // q + half of three rate products, rounded back to Q2.30
        function wide_t integ(wide_t q, wide_t p0, wide_t p1, wide_t p2, inout bit sat);
            wide_t acc;
            acc = (q <<< 29) + (p0 >>> 2) + (p1 >>> 2) + (p2 >>> 2);
            return clip((acc + RND_ACC) >>> 29, sat);
        endfunction

        function uwide_t root_floor(uwide_t n);
            uwide_t res, b;
            res = 0;
            b = uwide_t'(1) << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function uwide_t magn(wide_t c);
            return uwide_t'(c < 0 ? -c : c);
        endfunction

        function logic signed [QUAT_WIDTH-1:0] unit_comp(wide_t c, uwide_t r);
            uwide_t m, qv;
            m = magn(c) << 30;
            qv = (2 * m + r) / (2 * r);
            return c < 0 ? -qv[31:0] : qv[31:0];
        endfunction

        function void note_input(in_word_t wd);
            orient_word_t e;
            bit sat;
            wide_t step, dx, dy, dz, w, x, y, z, nw, nx, ny, nz;
            uwide_t s, r;
            sat = 0;
            e.zero_norm = 0;
            if (wd.action == ACT_LOAD) begin
                n_load++;
                qw = wd.load_w; qx = wd.load_x; qy = wd.load_y; qz = wd.load_z;
            end else begin
                n_integ++;
                step = wide_t'({1'b0, wd.step_scale});
                dx = clip((wide_t'(wd.rate_x) * step + RND_RATE) >>> 22, sat);
                dy = clip((wide_t'(wd.rate_y) * step + RND_RATE) >>> 22, sat);
                dz = clip((wide_t'(wd.rate_z) * step + RND_RATE) >>> 22, sat);
                w = wide_t'(qw); x = wide_t'(qx); y = wide_t'(qy); z = wide_t'(qz);
                nw = integ(w, -(dx * x), -(dy * y), -(dz * z), sat);
                nx = integ(x, dx * w, dy * z, -(dz * y), sat);
                ny = integ(y, dy * w, dz * x, -(dx * z), sat);
                nz = integ(z, dz * w, dx * y, -(dy * x), sat);
                if (nw == 0 && nx == 0 && ny == 0 && nz == 0) begin
                    e.zero_norm = 1;
                    n_zero++;
                    reset_state();
                end else begin
                    s = magn(nw) * magn(nw) + magn(nx) * magn(nx)
                      + magn(ny) * magn(ny) + magn(nz) * magn(nz);
                    // all four at -2.0: sum is 2^64, root pinned to 2^32
                    r = (s > S_FULL) ? (uwide_t'(1) << 32) : root_floor(s);
                    qw = unit_comp(nw, r);
                    qx = unit_comp(nx, r);
                    qy = unit_comp(ny, r);
                    qz = unit_comp(nz, r);
                end
                if (sat) n_sat++;
            end
            e.w = qw; e.x = qx; e.y = qy; e.z = qz;
            e.saturated = sat;
            expected_q.push_back(e);
        endfunction

        function void check_result(orient_word_t a);
            orient_word_t e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word w=%h x=%h y=%h z=%h",
                         $time, a.w, a.x, a.y, a.z);
                return;
            end
            e = expected_q.pop_front();
            if (a.w !== e.w || a.x !== e.x || a.y !== e.y || a.z !== e.z ||
                a.zero_norm !== e.zero_norm || a.saturated !== e.saturated) begin
                errors++;
                $display("%0t: mismatch exp w=%h x=%h y=%h z=%h zn=%b sat=%b",
                         $time, e.w, e.x, e.y, e.z, e.zero_norm, e.saturated);
                $display("%0t:          act w=%h x=%h y=%h z=%h zn=%b sat=%b",
                         $time, a.w, a.x, a.y, a.z, a.zero_norm, a.saturated);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    qri_in_if  in_if();
    qri_out_if out_if();

    quaternion_rate_integrator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    orient_tracker tracker;
    int  cycles;
    int  words_sent;
    bit  calm_phase;     // no idling on either side
    logic hold_off;      // long receiver stall

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: check at the edge, then pick next ready.
    always @(posedge i_clk) begin
        orient_word_t got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.w = out_if.out_w; got.x = out_if.out_x;
            got.y = out_if.out_y; got.z = out_if.out_z;
            got.zero_norm = out_if.zero_norm;
            got.saturated = out_if.saturated;
            tracker.check_result(got);
        end
        if (hold_off)
            out_if.ready <= 1'b0;
        else if (calm_phase)
            out_if.ready <= 1'b1;
        else
            out_if.ready <= ($urandom_range(0, 99) >= 17);
    end

    // Long receiver stall while the sender keeps offering; fills the block.
    initial begin
        hold_off = 1'b0;
        wait (words_sent == 200);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (1500) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Offer one word; return once it is accepted.
    task automatic send_word(in_word_t wd);
        while (!calm_phase && $urandom_range(0, 99) < 17) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.action     <= wd.action;
        in_if.rate_x     <= wd.rate_x;
        in_if.rate_y     <= wd.rate_y;
        in_if.rate_z     <= wd.rate_z;
        in_if.step_scale <= wd.step_scale;
        in_if.load_w     <= wd.load_w;
        in_if.load_x     <= wd.load_x;
        in_if.load_y     <= wd.load_y;
        in_if.load_z     <= wd.load_z;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        tracker.note_input(wd);
        words_sent++;
    endtask

    function automatic in_word_t noise_word();
        in_word_t wd;
        wd.action     = ACT_INTEGRATE;
        wd.rate_x     = $urandom; wd.rate_y = $urandom; wd.rate_z = $urandom;
        wd.step_scale = $urandom;
        wd.load_w     = $urandom; wd.load_x = $urandom;
        wd.load_y     = $urandom; wd.load_z = $urandom;
        return wd;
    endfunction

    task automatic do_load(logic [31:0] w, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        in_word_t wd;
        wd = noise_word();
        wd.action = ACT_LOAD;
        wd.load_w = w; wd.load_x = x; wd.load_y = y; wd.load_z = z;
        send_word(wd);
    endtask

    task automatic do_integ(logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
                            logic [31:0] st);
        in_word_t wd;
        wd = noise_word();
        wd.rate_x = rx; wd.rate_y = ry; wd.rate_z = rz; wd.step_scale = st;
        send_word(wd);
    endtask

    initial begin
        in_word_t wd;
        int pick, drain;
        tracker = new();
        tracker.reset_state();
        cycles = 0;
        words_sent = 0;
        calm_phase = 0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.action = ACT_INTEGRATE;
        in_if.rate_x = 0; in_if.rate_y = 0; in_if.rate_z = 0;
        in_if.step_scale = 0;
        in_if.load_w = 0; in_if.load_x = 0; in_if.load_y = 0; in_if.load_z = 0;
        out_if.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        do_integ(32'h0, 32'h0, 32'h0, 32'h0);                  // from reset identity
        do_integ(32'h0010_0000, 32'h0008_0000, 32'hFFF0_0000, 32'h0100_0000);
        do_load(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        do_integ(32'h0, 32'h0, 32'h0, 32'h0);                  // unnormalized state
        do_load(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        do_integ(32'h0, 32'h0, 32'h0, 32'h0);                  // sum of squares = 2^64
        do_integ(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF); // rate clip
        do_integ(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        do_load(32'h0, 32'h0, 32'h0, 32'h0);
        do_integ(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'hFFFF_FFFF); // zero norm
        do_load(32'hC000_0000, 32'h0, 32'h0, 32'h0);
        do_integ(32'hFFF0_0000, 32'h0020_0000, 32'h0001_0000, 32'h0400_0000);
        do_load(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        do_integ(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001);
        do_load(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        do_integ(32'h4000_0000, 32'hC000_0000, 32'h2000_0000, 32'h8000_0000);
        do_load(32'h0000_0001, 32'h0, 32'h0, 32'h0);
        do_integ(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        do_load(QONE, 32'h0, 32'h0, 32'h0);

        // --- random: mostly integrations at realistic steps, some loads ---
        for (int i = 0; i < N_RANDOM; i++) begin
            calm_phase = (i >= 350 && i < 500);
            if (i == 700) begin
                // sender pause until the block has drained
                in_if.valid <= 1'b0;
                @(posedge i_clk);
                while (tracker.expected_q.size() != 0) @(posedge i_clk);
            end
            wd = noise_word();
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                wd.action = ACT_LOAD;
                wd.load_w = 0; wd.load_x = 0; wd.load_y = 0; wd.load_z = 0;
            end else if (pick < 7) begin
                wd.action = ACT_LOAD;                          // arbitrary quaternion
            end else if (pick < 12) begin
                wd.action = ACT_LOAD;                          // near identity
                wd.load_w = QONE - $urandom_range(0, 4096);
                wd.load_x = $signed($urandom_range(0, 8191)) - 4096;
            end else if (pick < 20) begin
                wd.step_scale = 0;
            end else if (pick < 40) begin
                // full-range step, rates as drawn
            end else begin
                wd.step_scale = $urandom_range(0, 32'h0010_0000);
            end
            send_word(wd);
        end
        calm_phase = 0;
        in_if.valid <= 1'b0;

        while (tracker.expected_q.size() != 0) @(posedge i_clk);
        drain = 300;
        repeat (drain) @(posedge i_clk);

        $display("run: %0d loads, %0d integrations (%0d zero-norm, %0d saturated)",
                 tracker.n_load, tracker.n_integ, tracker.n_zero, tracker.n_sat);
        $display("with random idles, a long output stall and a full drain mid-run");
        if (tracker.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d errors", tracker.errors);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
